@@ rtl/tlsf_pkg.sv @@
// tlsf_pkg: shared types, command codes and bit-scan helpers for the
// two-level segregated-fit class bitmap block. No dependencies.
`timescale 1ns / 1ps

package tlsf_pkg;

    localparam int MapBits   = 32;
    localparam int IndexBits = 5;
    localparam int SizeBits  = 32;
    localparam int MinBits   = 13;

    localparam logic [MinBits-1:0] MinSizeReset = 13'd32;

    // command codes; code 3 is unused and changes nothing
    localparam logic [1:0] CMD_MARK   = 2'd0;
    localparam logic [1:0] CMD_UNMARK = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    typedef struct packed {
        logic [1:0]          command;
        logic [SizeBits-1:0] block_size;
    } request_t;

    typedef struct packed {
        logic                 found;
        logic [IndexBits-1:0] class_first_level;
        logic [IndexBits-1:0] class_second_level;
    } result_t;

    typedef struct packed {
        logic [IndexBits-1:0] fl;
        logic [IndexBits-1:0] sl;
    } class_t;

    // index of the highest set bit, 0 for zero
    function automatic logic [IndexBits-1:0] top_bit(input logic [MapBits-1:0] v);
        logic [IndexBits-1:0] n;
        n = '0;
        for (int i = 0; i < MapBits; i++)
        begin
            if (v[i])
            begin
                n = IndexBits'(i);
            end
        end
        return n;
    endfunction

    // index of the lowest set bit, 0 for zero
    function automatic logic [IndexBits-1:0] low_bit(input logic [MapBits-1:0] v);
        logic [IndexBits-1:0] n;
        n = '0;
        for (int i = MapBits - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = IndexBits'(i);
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/tlsf_class_map.sv @@
// tlsf_class_map: maps a block size to its (first level, second level) class.
// Depends on tlsf_pkg.
`timescale 1ns / 1ps

module tlsf_class_map #(
    parameter int SIZE_WIDTH = 32,
    parameter int SL_SHIFT   = 5
) (
    input  logic [tlsf_pkg::SizeBits-1:0] size,
    input  logic [tlsf_pkg::MinBits-1:0]  min_size,
    output tlsf_pkg::class_t              cls
);
    import tlsf_pkg::*;

    localparam logic [IndexBits-1:0] SlMask = IndexBits'((1 << SL_SHIFT) - 1);
    localparam logic [IndexBits-1:0] SlShift = IndexBits'(SL_SHIFT);

    logic [SizeBits-1:0]  size_m;
    logic [SizeBits-1:0]  shifted;
    logic [IndexBits-1:0] f;

    always_comb
    begin
        // keep only the low SIZE_WIDTH bits
        for (int i = 0; i < SizeBits; i++)
        begin
            size_m[i] = size[i] & (i < SIZE_WIDTH);
        end
        f       = top_bit(size_m);
        shifted = size_m >> (f - SlShift);
        if (size_m == '0 || size_m < {{(SizeBits-MinBits){1'b0}}, min_size})
        begin
            cls.fl = '0;
            cls.sl = '0;
        end
        else
        begin
            cls.fl = f;
            cls.sl = (f < SlShift) ? '0 : (shifted[IndexBits-1:0] & SlMask);
        end
    end

endmodule

@@ rtl/tlsf_bitmap.sv @@
// tlsf_bitmap: first-level map and 32 second-level rows, with the
// mark / unmark update and the lowest-fit search. Depends on tlsf_pkg.
`timescale 1ns / 1ps

module tlsf_bitmap (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    input  logic [1:0]           command,
    input  tlsf_pkg::class_t     cls,
    output tlsf_pkg::result_t    res
);
    import tlsf_pkg::*;

    logic [MapBits-1:0] row_reg  [MapBits];
    logic [MapBits-1:0] row_next [MapBits];
    logic [MapBits-1:0] flm_reg;
    logic [MapBits-1:0] flm_next;

    logic [MapBits-1:0] lane [MapBits];
    logic [MapBits-1:0] hit;
    logic [MapBits-1:0] nonempty;
    logic [MapBits-1:0] sl_mask;
    logic [MapBits-1:0] sl_bit;
    logic [IndexBits-1:0] win;

    always_comb
    begin
        sl_mask = {MapBits{1'b1}} << cls.sl;
        sl_bit  = {{(MapBits-1){1'b0}}, 1'b1} << cls.sl;
        // each row is a lane: the class row masked from sl up, rows above it whole
        for (int r = 0; r < MapBits; r++)
        begin
            if (IndexBits'(r) == cls.fl)
            begin
                lane[r] = row_reg[r] & sl_mask;
            end
            else if (IndexBits'(r) > cls.fl && flm_reg[r])
            begin
                lane[r] = row_reg[r];
            end
            else
            begin
                lane[r] = '0;
            end
            hit[r]      = |lane[r];
            nonempty[r] = |row_reg[r];
        end
        win = low_bit(hit);

        res.found              = 1'b0;
        res.class_first_level  = cls.fl;
        res.class_second_level = cls.sl;
        case (command)
            CMD_MARK, CMD_UNMARK:
            begin
                res.found = 1'b1;
            end
            CMD_SEARCH:
            begin
                if (|hit)
                begin
                    res.found              = 1'b1;
                    res.class_first_level  = win;
                    res.class_second_level = low_bit(lane[win]);
                end
            end
            default:
            begin
                res.found = 1'b0;
            end
        endcase

        for (int r = 0; r < MapBits; r++)
        begin
            row_next[r] = row_reg[r];
            flm_next[r] = flm_reg[r];
            if (valid && IndexBits'(r) == cls.fl)
            begin
                if (command == CMD_MARK)
                begin
                    row_next[r] = row_reg[r] | sl_bit;
                    flm_next[r] = 1'b1;
                end
                else if (command == CMD_UNMARK)
                begin
                    row_next[r] = row_reg[r] & ~sl_bit;
                    flm_next[r] = |row_next[r];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flm_reg <= '0;
            for (int r = 0; r < MapBits; r++)
            begin
                row_reg[r] <= '0;
            end
        end
        else
        begin
            flm_reg <= flm_next;
            for (int r = 0; r < MapBits; r++)
            begin
                row_reg[r] <= row_next[r];
            end
        end
    end

    // first-level bit tracks row occupancy
    a_flm_matches_rows: assert property (@(posedge clk) disable iff (!rst_n)
        flm_reg == nonempty)
        else $error("first-level map out of step with rows");

    // a found class is never below the requested one
    a_search_at_or_above: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && command == CMD_SEARCH && res.found) |->
            (res.class_first_level > cls.fl) ||
            (res.class_first_level == cls.fl && res.class_second_level >= cls.sl))
        else $error("search returned a class below the request");

    // mark leaves its first-level bit set
    a_mark_sets_fl: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && command == CMD_MARK) |=> flm_reg[$past(cls.fl)])
        else $error("mark did not set first-level bit");

endmodule

@@ rtl/two_level_free_class_bitmap.sv @@
// two_level_free_class_bitmap: top level of the segregated-fit class index
// and bitmap engine. Depends on tlsf_pkg, tlsf_class_map, tlsf_bitmap.
`timescale 1ns / 1ps
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  request   | start / busy       | request_t: command, block_size
//  result    | done (1-cycle)     | result_t: found, first / second level
//  config    | cfg_we             | cfg_wdata: min_block_size
//
//  A request transfer happens on a clock edge with start high and busy low.
//  busy is never raised: one request is taken every cycle.
//  The request is registered, mapped to its class and searched / updated in
//  the following cycle; the result register loads at the next edge, so done
//  is high together with the new result, for exactly one cycle.
//  Sustained rate is one item per cycle; latency is set by the input and
//  result registers around the class map and bitmap logic.
//  Reset clears both maps and loads min_block_size with 32. The receiver
//  cannot stall; results are simply presented, with no hold for the receiver.

module two_level_free_class_bitmap #(
    parameter int SIZE_WIDTH = 32,
    parameter int SL_SHIFT   = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tlsf_pkg::request_t            request,
    output logic                          done,
    output tlsf_pkg::result_t             result,
    input  logic                          cfg_we,
    input  logic [tlsf_pkg::MinBits-1:0]  cfg_wdata
);
    import tlsf_pkg::*;

    logic                in_valid_reg;
    request_t            req_reg;
    logic [MinBits-1:0]  min_reg;
    logic                done_reg;
    result_t             result_reg;

    class_t              cls;
    result_t             res;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // size -> class
    tlsf_class_map #(
        .SIZE_WIDTH (SIZE_WIDTH),
        .SL_SHIFT   (SL_SHIFT)
    ) u_class_map (
        .size     (req_reg.block_size),
        .min_size (min_reg),
        .cls      (cls)
    );

    // maps, update and search
    tlsf_bitmap u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (in_valid_reg),
        .command (req_reg.command),
        .cls     (cls),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            min_reg      <= MinSizeReset;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
            if (cfg_we)
            begin
                min_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        if (in_valid_reg)
        begin
            result_reg <= res;
        end
    end

endmodule

@@ verif/tb_two_level_free_class_bitmap.sv @@
// tb_two_level_free_class_bitmap: self-checking bench for the segregated-fit
// class bitmap block; models the class mapping and both maps in-bench.
// Depends on tlsf_pkg and the two_level_free_class_bitmap RTL.
`timescale 1ns / 1ps

module tb_two_level_free_class_bitmap;

    import tlsf_pkg::*;

    localparam int SlShift = 5;

    // Code 3 is not decoded by the block; the bench names it for stimulus.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input is known from time zero.
    // ------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    request_t           request   = '0;
    logic               done;
    result_t            result;
    logic               cfg_we    = 1'b0;
    logic [MinBits-1:0] cfg_wdata = '0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    two_level_free_class_bitmap #(
        .SIZE_WIDTH (32),
        .SL_SHIFT   (SlShift)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Bench-side copy of the block state. Updated at each accepted
    // transfer, so predictions follow the same order as the hardware.
    // ------------------------------------------------------------------
    logic [MapBits-1:0] level_map = '0;
    logic [MapBits-1:0] row_maps [MapBits];
    logic [MinBits-1:0] min_size_model = MinSizeReset;

    result_t     pending_lookups [$];
    logic [31:0] live_sizes [$];       // sizes marked and not yet unmarked

    int unsigned error_count     = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned sender_idle_pct = 0;

    initial
    begin
        for (int i = 0; i < MapBits; i++)
        begin
            row_maps[i] = '0;
        end
    end

    function automatic logic [IndexBits-1:0] top_set_index(input logic [31:0] v);
        logic [IndexBits-1:0] idx;
        idx = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                idx = i[IndexBits-1:0];
            end
        end
        return idx;
    endfunction

    function automatic logic [IndexBits-1:0] low_set_index(input logic [31:0] v);
        logic [IndexBits-1:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = i[IndexBits-1:0];
            end
        end
        return idx;
    endfunction

    // Size to (first level, second level). Zero and sub-minimum sizes go
    // to class 0,0; a top bit under SlShift leaves no room for a second level.
    function automatic class_t size_class(input logic [31:0] size);
        class_t cls;
        logic [IndexBits-1:0] f;
        logic [31:0] shifted;
        cls = '0;
        if (size != 32'd0 && size >= {19'd0, min_size_model})
        begin
            f = top_set_index(size);
            cls.fl = f;
            if (int'(f) >= SlShift)
            begin
                shifted = size >> (int'(f) - SlShift);
                cls.sl = shifted[IndexBits-1:0];
            end
        end
        return cls;
    endfunction

    // Applies one command to the model maps and returns the result it yields.
    function automatic result_t predict_class_lookup(input request_t req);
        result_t res;
        class_t cls;
        logic [31:0] row;
        logic [63:0] upper;
        logic [IndexBits-1:0] f;
        cls = size_class(req.block_size);
        res.found = 1'b0;
        res.class_first_level = cls.fl;
        res.class_second_level = cls.sl;
        case (req.command)
            CMD_MARK:
            begin
                row_maps[cls.fl][cls.sl] = 1'b1;
                level_map[cls.fl] = 1'b1;
                res.found = 1'b1;
            end
            CMD_UNMARK:
            begin
                // unmarking an empty class still drops an empty row's level bit
                row_maps[cls.fl][cls.sl] = 1'b0;
                if (row_maps[cls.fl] == '0)
                begin
                    level_map[cls.fl] = 1'b0;
                end
                res.found = 1'b1;
            end
            CMD_SEARCH:
            begin
                row = row_maps[cls.fl] & (32'hFFFF_FFFF << cls.sl);
                f = cls.fl;
                if (row == '0)
                begin
                    upper = {32'd0, level_map} & ({64{1'b1}} << (int'(cls.fl) + 1));
                    if (upper != '0)
                    begin
                        f = low_set_index(upper[31:0]);
                        row = row_maps[f];
                    end
                end
                // not found: keep the class computed from the size
                if (row != '0)
                begin
                    res.found = 1'b1;
                    res.class_first_level = f;
                    res.class_second_level = low_set_index(row);
                end
            end
            default:
            begin
                // unused code: maps untouched, found stays low
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request monitor: a transfer is start high and busy low at the edge.
    // Values read here are the pre-edge ones, since the driver uses NBAs.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                min_size_model <= cfg_wdata;
            end
            if (start && !busy)
            begin
                pending_lookups.push_back(predict_class_lookup(request));
            end
        end
    end

    task automatic report_mismatch(input string what, input int unsigned exp_val,
                                   input int unsigned got_val);
        error_count++;
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what,
                 exp_val, got_val);
    endtask

    // Result checker: done marks a one-cycle result that cannot be held off.
    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
            begin
                report_mismatch("result with nothing pending", 0, 1);
            end
            else
            begin
                exp_res = pending_lookups.pop_front();
                results_checked++;
                if (result.found !== exp_res.found)
                begin
                    report_mismatch("found", 32'(exp_res.found), 32'(result.found));
                end
                if (result.class_first_level !== exp_res.class_first_level)
                begin
                    report_mismatch("class_first_level", 32'(exp_res.class_first_level),
                                    32'(result.class_first_level));
                end
                if (result.class_second_level !== exp_res.class_second_level)
                begin
                    report_mismatch("class_second_level", 32'(exp_res.class_second_level),
                                    32'(result.class_second_level));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver. start is left high after a transfer so back-to-back items
    // need no drop; it only goes low when the sender decides to idle.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] size);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= '{command: cmd, block_size: size};
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Hold the sender off until every predicted result has been seen.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_lookups.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Register writes happen only with the pipe empty, plus a wait to cover
    // the two register stages.
    task automatic write_min_size(input logic [MinBits-1:0] value);
        wait_for_results();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly sizes with a top bit in a few focus rows so classes collide;
    // the rest are tiny, near the minimum, or fully random.
    function automatic logic [31:0] rand_block_size(input int focus_row);
        logic [31:0] one_hot;
        int f;
        case ($urandom_range(0, 9))
            0:       return 32'($urandom_range(0, 64));
            1:       return $urandom;
            2:       return {19'd0, min_size_model} + 32'($urandom_range(0, 4)) - 32'd2;
            default:
            begin
                f = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                : focus_row + $urandom_range(0, 3);
                one_hot = 32'd1 << f;
                return one_hot | ($urandom & (one_hot - 32'd1));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Reset minimum of 32: extremes of size, not-found search, unused code.
    task automatic test_class_mapping();
        send_item(CMD_SEARCH, 32'd0);            // empty maps: not found at 0,0
        send_item(CMD_MARK,   32'd0);            // zero size lands in 0,0
        send_item(CMD_MARK,   32'hFFFF_FFFF);    // top class 31,31
        send_item(CMD_SEARCH, 32'd1);            // below minimum, finds 0,0
        send_item(CMD_SEARCH, 32'd33);           // row 5 empty, climbs to row 31
        send_item(CMD_UNUSED, 32'd100);          // no effect, found low
        send_item(CMD_UNMARK, 32'hFFFF_FFFF);    // row 31 empties
        send_item(CMD_UNMARK, 32'd12345);        // class was never marked
        send_item(CMD_SEARCH, 32'hFFFF_FFFF);    // nothing above: not found
        send_item(CMD_UNUSED, 32'hFFFF_FFFF);
    endtask

    // Minimum of zero: zero still maps to 0,0; short sizes have no second level.
    task automatic test_small_sizes();
        write_min_size('0);
        send_item(CMD_MARK,   32'd1);
        send_item(CMD_MARK,   32'd7);
        send_item(CMD_MARK,   32'd31);
        send_item(CMD_MARK,   32'd32);
        send_item(CMD_MARK,   32'd63);
        send_item(CMD_SEARCH, 32'd8);            // row 3 empty, finds 4,0
        send_item(CMD_SEARCH, 32'd0);
    endtask

    // Minimum of 4096: the boundary value itself and one below it.
    task automatic test_min_bound();
        write_min_size(13'd4096);
        send_item(CMD_MARK,   32'd4095);         // below minimum: 0,0
        send_item(CMD_MARK,   32'd4096);         // 12,0
        send_item(CMD_SEARCH, 32'd2048);
        send_item(CMD_UNMARK, 32'd0);
        send_item(CMD_SEARCH, 32'd5000);         // 12,7 and up: not found
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input logic [MinBits-1:0] min_value);
        int focus_row;
        int pick;
        int idx;
        logic [31:0] size;
        logic [1:0] cmd;
        write_min_size(min_value);
        sender_idle_pct = idle_pct;
        focus_row = $urandom_range(0, 28);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                wait_for_results();
            end
            pick = $urandom_range(0, 99);
            size = rand_block_size(focus_row);
            if (pick < 38)
            begin
                cmd = CMD_MARK;
                if (live_sizes.size() < 48)
                begin
                    live_sizes.push_back(size);
                end
                else
                begin
                    live_sizes[$urandom_range(0, 47)] = size;
                end
            end
            else if (pick < 66)
            begin
                cmd = CMD_UNMARK;
                // mostly retire something marked earlier so rows really empty
                if (live_sizes.size() != 0 && $urandom_range(0, 9) < 7)
                begin
                    idx = $urandom_range(0, live_sizes.size() - 1);
                    size = live_sizes[idx];
                    live_sizes.delete(idx);
                end
            end
            else if (pick < 95)
            begin
                cmd = CMD_SEARCH;
            end
            else
            begin
                cmd = CMD_UNUSED;
            end
            send_item(cmd, size);
        end
        sender_idle_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int drain_cycles;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 34;
        test_class_mapping();
        test_small_sizes();
        test_min_bound();

        test_random_traffic(430, 34, 13'd1);
        test_random_traffic(430, 85, 13'd4095);
        test_random_traffic(440, 0, 13'($urandom_range(1, 4096)));

        // drain, bounded, then let the pipe settle
        start <= 1'b0;
        drain_cycles = 0;
        while (pending_lookups.size() != 0 && drain_cycles < 1000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (4) @(posedge clk);
        if (pending_lookups.size() != 0)
        begin
            report_mismatch("results never arrived", 0, pending_lookups.size());
        end

        $display("covered %0d transfers and %0d checked results over six minimum sizes,",
                 items_sent, results_checked);
        $display("with mark, unmark, search and the unused code under three idle levels");
        if (error_count == 0)
        begin
            $display("tb_two_level_free_class_bitmap: done, clean");
        end
        else
        begin
            $display("tb_two_level_free_class_bitmap: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("tb_two_level_free_class_bitmap: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tlsf_pkg.sv
rtl/tlsf_class_map.sv
rtl/tlsf_bitmap.sv
rtl/two_level_free_class_bitmap.sv
verif/tb_two_level_free_class_bitmap.sv
